### design/assert_macros.svh
// assertion macros used by the timer manager modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that an implication holds at every rising clock edge outside reset
`define CHECK_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");
// check that a condition never holds outside reset
`define CHECK_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("check failed");
`endif

### design/dltm_pkg.sv
// shared constants and types of the delta list timer manager
package dltm_pkg;
   localparam int NUM_TIMERS = 16;
   localparam int TICK_WIDTH = 32;
   localparam int ID_WIDTH = $clog2(NUM_TIMERS);
   localparam int CNT_WIDTH = $clog2(NUM_TIMERS + 1);

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // one write request to the entry memory, delta and link with their own address
   typedef struct packed {
      logic                  delta_we;
      logic                  link_we;
      logic [ID_WIDTH-1:0]   addr;
      logic [ID_WIDTH-1:0]   link_addr;
      logic [TICK_WIDTH-1:0] delta;
      logic [ID_WIDTH-1:0]   link;
   } mem_wr_type;
endpackage

### design/dltm_entry_ram.sv
// entry memory holding the tick delta and next link of every timer
module dltm_entry_ram (
   input  logic                            clock,
   input  dltm_pkg::mem_wr_type            wr,
   input  logic [dltm_pkg::ID_WIDTH-1:0]   rd_addr,
   output logic [dltm_pkg::TICK_WIDTH-1:0] rd_delta,
   output logic [dltm_pkg::ID_WIDTH-1:0]   rd_link
);
   import dltm_pkg::*;

   logic [TICK_WIDTH-1:0] delta_mem [NUM_TIMERS];
   logic [ID_WIDTH-1:0]   link_mem [NUM_TIMERS];

   // synchronous write and registered read
   always_ff @(posedge clock) begin
      if (wr.delta_we) begin
         delta_mem[wr.addr] <= wr.delta;
      end
      if (wr.link_we) begin
         link_mem[wr.link_addr] <= wr.link;
      end
      rd_delta <= delta_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
   end
endmodule

### design/delta_list_timer_manager.sv
// top level: list sequencer of the delta list timer manager
// stop/start walk the list of armed timers; a tick reads the head and pops one head per expiry
// result stalls lengthen a tick with expiries
// every list step is one registered read of the entry memory and one compare
// one item is worked on at a time; the result register lets the next item enter
// reset clears head, count and armed flags at once; the entry memory needs no clearing
module delta_list_timer_manager (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // operation[1:0], timer_id[5:2], delay_ticks[37:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // expired_timer[3:0]
   output logic        rsp_tlast    // last_expiry
);
   import dltm_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_RM_RD, S_RM_WAIT, S_RM_FIX, S_IN_RD, S_IN_WAIT, S_IN_FIN,
      S_TK_WAIT, S_TK_DEC, S_EX_RD, S_EX_WAIT, S_EX_OUT
   } state_type;

   state_type             state_ff;
   logic [1:0]            op_ff;
   logic [ID_WIDTH-1:0]   id_ff;
   logic [TICK_WIDTH-1:0] t_ff;
   logic [ID_WIDTH-1:0]   head_ff, cur_ff, prev_ff;
   logic                  has_prev_ff;
   logic [CNT_WIDTH-1:0]  count_ff, k_ff;
   logic [NUM_TIMERS-1:0] armed_ff;
   logic [TICK_WIDTH-1:0] id_delta_ff;
   logic [ID_WIDTH-1:0]   id_link_ff;
   logic                  out_valid_ff, out_last_ff;
   logic [ID_WIDTH-1:0]   out_id_ff;

   mem_wr_type            wr;
   logic [ID_WIDTH-1:0]   rd_addr;
   logic [TICK_WIDTH-1:0] rd_delta;
   logic [ID_WIDTH-1:0]   rd_link;

   logic [1:0]            req_op;
   logic [ID_WIDTH-1:0]   req_id;
   logic [TICK_WIDTH-1:0] req_delay;
   logic                  req_fire;

   assign req_op    = req_tdata[1:0];
   assign req_id    = req_tdata[2 +: ID_WIDTH];
   assign req_delay = req_tdata[6 +: TICK_WIDTH];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(8-ID_WIDTH){1'b0}}, out_id_ff};

   dltm_entry_ram u_ram (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_delta (rd_delta),
      .rd_link  (rd_link)
   );

   // read address and memory writes of the current step
   always_comb begin
      wr = '0;
      rd_addr = cur_ff;
      case (state_ff)
         S_RM_FIX: begin
            // removal: add the removed delta to the successor delta, if there is a successor
            if (k_ff > CNT_WIDTH'(0)) begin
               wr.delta_we = 1'b1;
               wr.addr = id_link_ff;
               wr.delta = rd_delta + id_delta_ff;
            end
         end
         S_IN_WAIT: begin
            if (!(k_ff < count_ff && t_ff > rd_delta)) begin
               wr.delta_we = 1'b1;
               wr.link_we = 1'b1;
               wr.addr = id_ff;
               wr.link_addr = id_ff;
               wr.delta = t_ff;
               wr.link = (k_ff < count_ff) ? cur_ff : '0;
            end
         end
         S_IN_FIN: begin
            // successor delta shrinks by the new entry
            if (k_ff < count_ff) begin
               wr.delta_we = 1'b1;
               wr.addr = cur_ff;
               wr.delta = rd_delta - t_ff;
            end
         end
         S_TK_DEC: begin
            if (rd_delta != '0) begin
               wr.delta_we = 1'b1;
               wr.addr = head_ff;
               wr.delta = rd_delta - TICK_WIDTH'(1);
            end
         end
         default: ;
      endcase
      // predecessor link writes
      if (state_ff == S_RM_WAIT && cur_ff == id_ff && has_prev_ff) begin
         wr.link_we = 1'b1;
         wr.link_addr = prev_ff;
         wr.link = rd_link;
      end
      if (state_ff == S_IN_FIN && has_prev_ff) begin
         wr.link_we = 1'b1;
         wr.link_addr = prev_ff;
         wr.link = id_ff;
      end
      if (state_ff == S_RM_WAIT && cur_ff == id_ff) begin
         rd_addr = rd_link;
      end
      // popping the head: read the next head right away
      if (state_ff == S_EX_WAIT && (!out_valid_ff || rsp_tready)) begin
         rd_addr = rd_link;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         armed_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff <= req_op;
                  id_ff <= req_id;
                  t_ff  <= req_delay;
                  cur_ff <= head_ff;
                  has_prev_ff <= 1'b0;
                  k_ff <= '0;
                  if (req_op == OP_START || req_op == OP_STOP) begin
                     state_ff <= armed_ff[req_id] ? S_RM_RD
                               : (req_op == OP_START ? S_IN_RD : S_IDLE);
                  end else if (req_op == OP_TICK && count_ff != '0) begin
                     state_ff <= S_TK_WAIT;
                  end
               end
            end
            // removal walk
            S_RM_RD: state_ff <= S_RM_WAIT;
            S_RM_WAIT: begin
               if (cur_ff == id_ff) begin
                  id_delta_ff <= rd_delta;
                  id_link_ff  <= rd_link;
                  armed_ff[id_ff] <= 1'b0;
                  if (!has_prev_ff) head_ff <= rd_link;
                  k_ff <= (k_ff + CNT_WIDTH'(1) < count_ff) ? CNT_WIDTH'(1) : '0;
                  count_ff <= count_ff - CNT_WIDTH'(1);
                  state_ff <= S_RM_FIX;
               end else begin
                  prev_ff <= cur_ff;
                  has_prev_ff <= 1'b1;
                  cur_ff <= rd_link;
                  k_ff <= k_ff + CNT_WIDTH'(1);
                  state_ff <= S_RM_RD;
               end
            end
            S_RM_FIX: begin
               has_prev_ff <= 1'b0;
               k_ff <= '0;
               cur_ff <= head_ff;
               state_ff <= (op_ff == OP_START) ? S_IN_RD : S_IDLE;
            end
            // insertion walk
            S_IN_RD: state_ff <= S_IN_WAIT;
            S_IN_WAIT: begin
               if (k_ff < count_ff && t_ff > rd_delta) begin
                  t_ff <= t_ff - rd_delta;
                  prev_ff <= cur_ff;
                  has_prev_ff <= 1'b1;
                  cur_ff <= rd_link;
                  k_ff <= k_ff + CNT_WIDTH'(1);
                  state_ff <= S_IN_RD;
               end else begin
                  state_ff <= S_IN_FIN;
               end
            end
            S_IN_FIN: begin
               if (!has_prev_ff) head_ff <= id_ff;
               armed_ff[id_ff] <= 1'b1;
               count_ff <= count_ff + CNT_WIDTH'(1);
               state_ff <= S_IDLE;
            end
            // tick: read head, decrement
            S_TK_WAIT: state_ff <= S_TK_DEC;
            S_TK_DEC: begin
               cur_ff <= head_ff;
               state_ff <= (rd_delta <= TICK_WIDTH'(1)) ? S_EX_RD : S_IDLE;
            end
            S_EX_RD: state_ff <= S_EX_WAIT;
            // pop the head once the result register is free
            S_EX_WAIT: begin
               if (!out_valid_ff || rsp_tready) begin
                  out_id_ff <= cur_ff;
                  armed_ff[cur_ff] <= 1'b0;
                  head_ff <= rd_link;
                  cur_ff <= rd_link;
                  count_ff <= count_ff - CNT_WIDTH'(1);
                  state_ff <= S_EX_OUT;
               end
            end
            S_EX_OUT: begin
               // next head is read, decide whether it expires too
               out_valid_ff <= 1'b1;
               if (count_ff != '0 && rd_delta == '0) begin
                  out_last_ff <= 1'b0;
                  state_ff <= S_EX_WAIT;
               end else begin
                  out_last_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `CHECK_IMPL(a_count_ok, clock, reset, 1'b1, count_ff <= CNT_WIDTH'(NUM_TIMERS))
   `CHECK_IMPL(a_count_match, clock, reset, state_ff == S_IDLE, $countones(armed_ff) == int'(count_ff))
   `CHECK_NEVER(a_no_accept_busy, clock, reset, req_fire && state_ff != S_IDLE)
endmodule
